// ===== rtl/mcg_pkg.sv =====
// Shared types, constants and helper functions for the month calendar grid.
`timescale 1ns / 1ps

package mcg_pkg;

  localparam int unsigned YearW     = 14;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned DayW      = 5;
  localparam int unsigned CellW     = 6;
  localparam int unsigned GridCells = 42;
  localparam int unsigned LastCell  = GridCells - 1;

  // Descriptor queue between the front and the back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = 2;
  localparam int unsigned QCntW  = 3;

  // Number of front pipeline stages holding an item before it enters the queue.
  localparam int unsigned FrontStages = 4;

  // Reciprocals used for constant division: floor(x * R >> S) == floor(x / D)
  // over the value ranges seen here.
  localparam int unsigned Recip100  = 5243;
  localparam int unsigned Shift100  = 19;
  localparam int unsigned Recip7    = 2341;
  localparam int unsigned Shift7    = 14;

  typedef enum logic [1:0] {
    PrevMonth = 2'd0,
    ThisMonth = 2'd1,
    NextMonth = 2'd2
  } mcg_which_e;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  today_year;
    logic [MonthW-1:0] today_month;
    logic [DayW-1:0]   today_day;
  } mcg_in_t;

  typedef struct packed {
    logic [CellW-1:0] cell_index;
    logic [DayW-1:0]  day_number;
    mcg_which_e       cell_month;
    logic             is_today;
    logic             last_cell;
  } mcg_out_t;

  // Everything the back needs to lay out one month.
  typedef struct packed {
    logic [2:0]      start_col;
    logic [DayW-1:0] dim;
    logic [DayW-1:0] dim_prev;
    logic            month_match;
    logic [DayW-1:0] today_day;
  } mcg_desc_t;

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] d;
    case (m)
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  // Month term of Zeller's congruence, 1 + (13 * (mm + 1)) / 5, with January
  // and February counted as months 13 and 14 of the year before.
  function automatic logic [5:0] zeller_month_term(input logic [MonthW-1:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd37;
      4'd2:    t = 6'd40;
      4'd3:    t = 6'd11;
      4'd4:    t = 6'd14;
      4'd5:    t = 6'd16;
      4'd6:    t = 6'd19;
      4'd7:    t = 6'd21;
      4'd8:    t = 6'd24;
      4'd9:    t = 6'd27;
      4'd10:   t = 6'd29;
      4'd11:   t = 6'd32;
      default: t = 6'd34;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/mcg_front.sv =====
// Front pipeline: takes requests and reduces each to a month layout descriptor.
`timescale 1ns / 1ps

module mcg_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mcg_pkg::mcg_in_t           in_i,
  input  logic [mcg_pkg::QCntW-1:0]  q_count_i,
  output logic                       push_o,
  output mcg_pkg::mcg_desc_t         desc_o
);

  logic accept;

  // Stage 1: effective year and month.
  logic                             s1_valid_q;
  logic [mcg_pkg::YearW-1:0]        s1_year_q;
  logic [mcg_pkg::MonthW-1:0]       s1_month_q;
  logic [mcg_pkg::YearW:0]          s1_zyear_q;
  logic                             s1_match_q;
  logic [mcg_pkg::DayW-1:0]         s1_td_q;

  // Stage 2: quotients by one hundred.
  logic                             s2_valid_q;
  logic [mcg_pkg::YearW-1:0]        s2_year_q;
  logic [mcg_pkg::MonthW-1:0]       s2_month_q;
  logic [mcg_pkg::YearW:0]          s2_zyear_q;
  logic [7:0]                       s2_zq_q;
  logic [7:0]                       s2_lq_q;
  logic                             s2_match_q;
  logic [mcg_pkg::DayW-1:0]         s2_td_q;

  // Stage 3: Zeller sum and month lengths.
  logic                             s3_valid_q;
  logic [10:0]                      s3_sum_q;
  logic [mcg_pkg::DayW-1:0]         s3_dim_q;
  logic [mcg_pkg::DayW-1:0]         s3_dim_prev_q;
  logic                             s3_match_q;
  logic [mcg_pkg::DayW-1:0]         s3_td_q;

  // Stage 4: quotient by seven.
  logic                             s4_valid_q;
  logic [10:0]                      s4_sum_q;
  logic [7:0]                       s4_q7_q;
  logic [mcg_pkg::DayW-1:0]         s4_dim_q;
  logic [mcg_pkg::DayW-1:0]         s4_dim_prev_q;
  logic                             s4_match_q;
  logic [mcg_pkg::DayW-1:0]         s4_td_q;

  // Stage 1 inputs.
  logic                             unset;
  logic [mcg_pkg::YearW-1:0]        eff_year;
  logic [mcg_pkg::MonthW-1:0]       raw_month;
  logic [mcg_pkg::MonthW-1:0]       eff_month;
  logic                             early;
  logic [mcg_pkg::YearW:0]          zyear;

  // Stage 2 inputs.
  logic [27:0]                      zprod;
  logic [27:0]                      lprod;

  // Stage 3 inputs.
  logic [6:0]                       zrem;
  logic [6:0]                       lrem;
  logic                             leap;
  logic [mcg_pkg::MonthW-1:0]       prev_month;
  logic [10:0]                      sum;

  // Stage 4 outputs.
  logic [22:0]                      q7prod;
  logic [2:0]                       h;

  logic [3:0]                       inflight;

  // Each stage in flight and each queued descriptor holds one queue slot.
  assign inflight = 4'(s1_valid_q) + 4'(s2_valid_q) + 4'(s3_valid_q) + 4'(s4_valid_q);
  assign in_stall_o = ({1'b0, q_count_i} + inflight) >= 4'(mcg_pkg::QDepth);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    unset     = (in_i.year == '0) || (in_i.month == '0);
    eff_year  = unset ? in_i.today_year : in_i.year;
    raw_month = unset ? in_i.today_month : in_i.month;
    if (raw_month == 4'd0) begin
      eff_month = 4'd1;
    end else if (raw_month > 4'd12) begin
      eff_month = 4'd12;
    end else begin
      eff_month = raw_month;
    end
    early = eff_month < 4'd3;
    zyear = {1'b0, eff_year} + 15'd400 - {14'b0, early};
  end

  assign zprod = {13'b0, s1_zyear_q} * 28'(mcg_pkg::Recip100);
  assign lprod = {14'b0, s1_year_q} * 28'(mcg_pkg::Recip100);

  always_comb begin
    zrem = 7'(s2_zyear_q - 15'({7'b0, s2_zq_q} * 15'd100));
    lrem = 7'(s2_year_q - 14'({6'b0, s2_lq_q} * 14'd100));
    leap = ((s2_year_q[1:0] == 2'b00) && (lrem != 7'd0)) ||
           ((lrem == 7'd0) && (s2_lq_q[1:0] == 2'b00));
    prev_month = (s2_month_q == 4'd1) ? 4'd12 : s2_month_q - 4'd1;
    sum = {5'b0, mcg_pkg::zeller_month_term(s2_month_q)}
        + {4'b0, zrem} + {6'b0, zrem[6:2]}
        + {5'b0, s2_zq_q[7:2]} + 11'({3'b0, s2_zq_q} * 11'd5);
  end

  assign q7prod = {12'b0, s3_sum_q} * 23'(mcg_pkg::Recip7);

  // Zeller gives 0 for Saturday; shift so that Monday is column 0.
  assign h = 3'(s4_sum_q - 11'({3'b0, s4_q7_q} * 11'd7));

  always_comb begin
    desc_o.start_col   = (h >= 3'd2) ? h - 3'd2 : h + 3'd5;
    desc_o.dim         = s4_dim_q;
    desc_o.dim_prev    = s4_dim_prev_q;
    desc_o.month_match = s4_match_q;
    desc_o.today_day   = s4_td_q;
  end

  assign push_o = s4_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_year_q  <= eff_year;
    s1_month_q <= eff_month;
    s1_zyear_q <= zyear;
    s1_match_q <= (eff_year == in_i.today_year) && (eff_month == in_i.today_month);
    s1_td_q    <= in_i.today_day;

    s2_year_q  <= s1_year_q;
    s2_month_q <= s1_month_q;
    s2_zyear_q <= s1_zyear_q;
    s2_zq_q    <= 8'(zprod >> mcg_pkg::Shift100);
    s2_lq_q    <= 8'(lprod >> mcg_pkg::Shift100);
    s2_match_q <= s1_match_q;
    s2_td_q    <= s1_td_q;

    s3_sum_q      <= sum;
    s3_dim_q      <= mcg_pkg::month_days(s2_month_q, leap);
    s3_dim_prev_q <= mcg_pkg::month_days(prev_month, leap);
    s3_match_q    <= s2_match_q;
    s3_td_q       <= s2_td_q;

    s4_sum_q      <= s3_sum_q;
    s4_q7_q       <= 8'(q7prod >> mcg_pkg::Shift7);
    s4_dim_q      <= s3_dim_q;
    s4_dim_prev_q <= s3_dim_prev_q;
    s4_match_q    <= s3_match_q;
    s4_td_q       <= s3_td_q;
  end

endmodule

// ===== rtl/mcg_queue.sv =====
// Short descriptor queue between the front pipeline and the cell sequencer.
`timescale 1ns / 1ps

module mcg_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  mcg_pkg::mcg_desc_t         push_desc_i,
  input  logic                       pop_i,
  output mcg_pkg::mcg_desc_t         head_desc_o,
  output logic [mcg_pkg::QCntW-1:0]  count_o
);

  mcg_pkg::mcg_desc_t              slot_q [mcg_pkg::QDepth];
  logic [mcg_pkg::QAddrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mcg_pkg::QAddrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mcg_pkg::QCntW-1:0]       count_q, count_d;

  assign head_desc_o = slot_q[rd_ptr_q];
  assign count_o     = count_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + mcg_pkg::QCntW'(push_i) - mcg_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

// ===== rtl/mcg_back.sv =====
// Cell sequencer: walks the 42 grid cells of one descriptor into the output register.
`timescale 1ns / 1ps

module mcg_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [mcg_pkg::QCntW-1:0]  q_count_i,
  input  mcg_pkg::mcg_desc_t         head_desc_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mcg_pkg::mcg_out_t          out_o
);

  logic                          active_q, active_d;
  logic [mcg_pkg::CellW-1:0]     cell_q, cell_d;
  mcg_pkg::mcg_desc_t            desc_q;
  logic                          out_valid_q, out_valid_d;
  mcg_pkg::mcg_out_t             out_q;
  mcg_pkg::mcg_out_t             cell_res;

  logic                          adv;
  logic                          fin;
  logic                          load;
  logic                          lead;
  logic [mcg_pkg::CellW-1:0]     start_ext;
  logic [mcg_pkg::CellW-1:0]     day_cur;
  logic [mcg_pkg::CellW-1:0]     day_lead;
  logic [mcg_pkg::CellW-1:0]     day_next;

  assign adv  = active_q && (!out_valid_q || !out_stall_i);
  assign fin  = adv && (cell_q == mcg_pkg::CellW'(mcg_pkg::LastCell));
  assign load = (!active_q || fin) && (q_count_i != '0);
  assign pop_o = load;

  always_comb begin
    start_ext = {3'b0, desc_q.start_col};
    lead      = cell_q < start_ext;
    day_cur   = cell_q - start_ext + 6'd1;
    day_lead  = {1'b0, desc_q.dim_prev} + 6'd1 + cell_q - start_ext;
    day_next  = day_cur - {1'b0, desc_q.dim};

    cell_res.cell_index = cell_q;
    cell_res.last_cell  = cell_q == mcg_pkg::CellW'(mcg_pkg::LastCell);
    cell_res.is_today   = 1'b0;
    if (lead) begin
      cell_res.day_number = day_lead[4:0];
      cell_res.cell_month = mcg_pkg::PrevMonth;
    end else if (day_cur <= {1'b0, desc_q.dim}) begin
      cell_res.day_number = day_cur[4:0];
      cell_res.cell_month = mcg_pkg::ThisMonth;
      cell_res.is_today   = desc_q.month_match && (day_cur[4:0] == desc_q.today_day);
    end else begin
      cell_res.day_number = day_next[4:0];
      cell_res.cell_month = mcg_pkg::NextMonth;
    end
  end

  always_comb begin
    active_d = active_q;
    cell_d   = cell_q;
    if (load) begin
      active_d = 1'b1;
      cell_d   = '0;
    end else if (fin) begin
      active_d = 1'b0;
    end else if (adv) begin
      cell_d = cell_q + 6'd1;
    end

    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cell_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      cell_q      <= cell_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      desc_q <= head_desc_i;
    end
    if (adv) begin
      out_q <= cell_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/month_calendar_grid.sv =====
// Top level of the month calendar grid: front pipeline, descriptor queue and cell sequencer.
`timescale 1ns / 1ps
// A request passes the four front stages and the queue before its first cell is registered out.
// Throughput: one cell per cycle while the output is not stalled, set by the cell sequencer.
// Items are taken while earlier ones are laid out: up to four wait beside the one in the back.
// Reset clears all valid flags, pointers and counters at once; there is no clearing pass.

module month_calendar_grid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mcg_pkg::mcg_in_t   in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mcg_pkg::mcg_out_t  out_o
);

  // The front works the request down to a small descriptor: the Monday-first
  // column of the first day (Zeller's congruence, with divisions by one
  // hundred and seven done as reciprocal multiplications over two stages),
  // the lengths of this and the previous month under the Gregorian leap
  // rule, and whether the displayed month is today's month.
  logic                          push;
  mcg_pkg::mcg_desc_t            push_desc;
  logic                          pop;
  mcg_pkg::mcg_desc_t            head_desc;
  logic [mcg_pkg::QCntW-1:0]     q_count;

  mcg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .q_count_i  (q_count),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  // The queue holds descriptors that wait for the sequencer. The front only
  // takes a request when a slot is reserved for it, so pushes never overflow.
  mcg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_desc_o (head_desc),
    .count_o     (q_count)
  );

  // The back steps a cell counter from 0 to 41 and derives each cell from
  // the descriptor. It loads the next descriptor on the same edge as it
  // issues the last cell, so consecutive grids follow without a gap.
  mcg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_count_i   (q_count),
    .head_desc_i (head_desc),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  // A descriptor is never pushed into a full queue unless one leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count != mcg_pkg::QCntW'(mcg_pkg::QDepth)) || pop)
    else $error("descriptor queue overflow");

  // The sequencer only pops when a descriptor is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_count != '0))
    else $error("descriptor queue underflow");

  // Today can only be marked on a cell of the displayed month.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.is_today) |-> (out_o.cell_month == mcg_pkg::ThisMonth))
    else $error("today marked outside the displayed month");

  // After the last cell of a grid is taken, the next cell issued starts a new grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_o.last_cell) |=>
      (!out_valid_o || (out_o.cell_index == '0)))
    else $error("grid did not restart at cell zero");

endmodule

// ===== sim/month_calendar_grid_checker.sv =====
// Checker for the month calendar grid: predicts the cells of every accepted request and compares.
`timescale 1ns / 1ps

module month_calendar_grid_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  mcg_pkg::mcg_in_t  in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  mcg_pkg::mcg_out_t out_item_i,
  output int unsigned       pending_o,
  output int unsigned       failures_o
);

  import mcg_pkg::*;

  mcg_out_t    expected_cells[$];
  int unsigned mismatch_count = 0;
  int unsigned cells_waiting = 0;

  assign pending_o  = cells_waiting;
  assign failures_o = mismatch_count;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    if (m == 2) begin
      return leap_year(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // Monday-first column of the first day of the month, from Zeller's congruence.
  // Four hundred years are added so that the January shift never goes below zero.
  function automatic int unsigned first_weekday(input int unsigned y, input int unsigned m);
    int unsigned yy, mm, k, j, h;
    yy = y + 400;
    mm = m;
    if (mm < 3) begin
      mm = mm + 12;
      yy = yy - 1;
    end
    k = yy % 100;
    j = yy / 100;
    h = (1 + (13 * (mm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return (h + 5) % 7;
  endfunction

  function automatic void lay_out_month(input mcg_in_t req);
    int unsigned y, m, start, dim, dim_prev, this_day, next_day, idx;
    bit          month_match;
    mcg_out_t    grid_cell;
    y = req.year;
    m = req.month;
    if (y == 0 || m == 0) begin
      y = req.today_year;
      m = req.today_month;
    end
    if (m == 0) begin
      m = 1;
    end else if (m > 12) begin
      m = 12;
    end
    start       = first_weekday(y, m);
    dim         = month_length(y, m);
    dim_prev    = month_length(y, (m == 1) ? 12 : m - 1);
    month_match = (y == req.today_year) && (m == req.today_month);
    this_day    = 1;
    next_day    = 1;
    for (idx = 0; idx < GridCells; idx++) begin
      grid_cell            = '0;
      grid_cell.cell_index = CellW'(idx);
      grid_cell.last_cell  = (idx == LastCell);
      if (idx < start) begin
        grid_cell.day_number = DayW'(dim_prev - start + 1 + idx);
        grid_cell.cell_month = PrevMonth;
      end else if (this_day <= dim) begin
        grid_cell.day_number = DayW'(this_day);
        grid_cell.cell_month = ThisMonth;
        grid_cell.is_today   = month_match && (this_day == req.today_day);
        this_day++;
      end else begin
        grid_cell.day_number = DayW'(next_day);
        grid_cell.cell_month = NextMonth;
        next_day++;
      end
      expected_cells.push_back(grid_cell);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : watch_channels
    mcg_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        lay_out_month(in_item_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_cells.size() == 0) begin
          $error("cell %0d came out with no cell expected", out_item_i.cell_index);
          mismatch_count++;
        end else begin
          want = expected_cells.pop_front();
          check_field("cell_index", want.cell_index, out_item_i.cell_index);
          check_field("day_number", want.day_number, out_item_i.day_number);
          check_field("cell_month", want.cell_month, out_item_i.cell_month);
          check_field("is_today", want.is_today, out_item_i.is_today);
          check_field("last_cell", want.last_cell, out_item_i.last_cell);
        end
      end
      cells_waiting <= expected_cells.size();
    end
  end

endmodule

// ===== sim/month_calendar_grid_tb.sv =====
// Testbench top for the month calendar grid: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module month_calendar_grid_tb;

  import mcg_pkg::*;

  // Number of random requests after the directed ones.
  localparam int unsigned RandomRequests = 450;
  // Settling time after the checker has no cells left waiting.
  localparam int unsigned DrainCycles = 40;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  mcg_in_t     in_item;
  logic        out_valid;
  logic        out_stall;
  mcg_out_t    out_item;
  int unsigned cells_pending;
  int unsigned failures;

  // When set, both sides run flat out so that back-to-back requests and cells are seen.
  bit calm = 1'b0;

  month_calendar_grid u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_item)
  );

  month_calendar_grid_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .pending_o   (cells_pending),
    .failures_o  (failures)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that never finishes ends with the error verdict.
  initial begin
    #10_000_000;
    $display("month_calendar_grid_tb: errors");
    $finish;
  end

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic mcg_in_t make_request(input int unsigned y, input int unsigned m,
                                           input int unsigned ty, input int unsigned tm,
                                           input int unsigned td);
    mcg_in_t req;
    req.year        = YearW'(y);
    req.month       = MonthW'(m);
    req.today_year  = YearW'(ty);
    req.today_month = MonthW'(tm);
    req.today_day   = DayW'(td);
    return req;
  endfunction

  // Most requests are well-formed dates, often with today inside the displayed month so
  // that today marking is exercised. The rest are an unset year or month, which falls back
  // on today's date, or raw bits in every field, which reach the clamping of the month.
  function automatic mcg_in_t random_request();
    mcg_in_t     req;
    int unsigned pick;
    pick        = $urandom_range(0, 9);
    req.year    = YearW'($urandom_range(1, 9999));
    req.month   = MonthW'($urandom_range(1, 12));
    if ($urandom_range(0, 9) < 4) begin
      req.today_year  = req.year;
      req.today_month = req.month;
    end else begin
      req.today_year  = YearW'($urandom_range(1, 9999));
      req.today_month = MonthW'($urandom_range(1, 12));
    end
    req.today_day = DayW'($urandom_range(1, 31));
    if (pick == 0) begin
      req.year        = YearW'($urandom);
      req.month       = MonthW'($urandom);
      req.today_year  = YearW'($urandom);
      req.today_month = MonthW'($urandom);
      req.today_day   = DayW'($urandom);
    end else if (pick == 1) begin
      if ($urandom_range(0, 1) == 0) begin
        req.year = '0;
      end else begin
        req.month = '0;
      end
      if ($urandom_range(0, 2) == 0) begin
        req.today_year  = YearW'($urandom);
        req.today_month = MonthW'($urandom);
      end
    end
    return req;
  endfunction

  // Offers one item after a drawn gap and returns on the edge at which it is taken.
  // Valid is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_request(input mcg_in_t req);
    int unsigned gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // Result side: before each cell it holds stall high for a drawn number of cycles, then
  // takes the next cell that turns up. Gaps thus fall anywhere within a month's cells.
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : request_source
    int unsigned n;
    in_valid = 1'b0;
    in_item  = '0;
    rst_n    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes of the year and month fields, with today on the first or last day of the month.
    send_request(make_request(1, 1, 1, 1, 1));
    send_request(make_request(9999, 12, 9999, 12, 31));
    send_request(make_request(16383, 15, 16383, 12, 31));
    send_request(make_request(1, 13, 1, 12, 5));
    // An unset display year or month takes today's year and month instead.
    send_request(make_request(0, 5, 2024, 2, 29));
    send_request(make_request(2000, 0, 2000, 2, 29));
    // Year zero counts as a leap year.
    send_request(make_request(0, 0, 0, 2, 29));
    // Today's month of zero or above twelve is clamped for the layout but never marks a day.
    send_request(make_request(0, 0, 1999, 0, 1));
    send_request(make_request(0, 0, 1999, 15, 31));
    // The century rules of the leap year.
    send_request(make_request(1900, 2, 1900, 2, 29));
    send_request(make_request(2100, 2, 2100, 2, 28));
    send_request(make_request(2004, 2, 2004, 3, 1));
    // Today's day of zero, a wrong year and a day beyond the month's end mark nothing.
    send_request(make_request(2024, 1, 2024, 1, 0));
    send_request(make_request(2024, 3, 2023, 3, 15));
    send_request(make_request(2024, 4, 2024, 4, 31));
    // A month opening on a Sunday, and a short month opening on a Monday.
    send_request(make_request(2023, 10, 2023, 10, 31));
    send_request(make_request(2021, 2, 2021, 2, 28));
    send_request(make_request(2015, 2, 2015, 2, 1));
    // December leads into January of the next year; an all-zero today matches nothing.
    send_request(make_request(2024, 12, 2024, 12, 25));
    send_request(make_request(16383, 1, 0, 0, 0));
    send_request(make_request(8191, 6, 8191, 6, 16));
    // The remaining months of the year.
    send_request(make_request(2025, 7, 2025, 7, 14));
    send_request(make_request(2025, 8, 2025, 8, 31));
    send_request(make_request(2025, 9, 2025, 9, 30));
    send_request(make_request(2025, 11, 2025, 11, 2));

    for (n = 0; n < RandomRequests; n++) begin
      if (n % 30 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      send_request(random_request());
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // The checker's count of waiting cells is registered, so it lags the acceptance edge.
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (failures == 0) begin
      $display("month_calendar_grid_tb: clean");
    end else begin
      $display("month_calendar_grid_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mcg_pkg.sv
rtl/mcg_front.sv
rtl/mcg_queue.sv
rtl/mcg_back.sv
rtl/month_calendar_grid.sv
sim/month_calendar_grid_checker.sv
sim/month_calendar_grid_tb.sv
